// ===== rtl/c8x_pkg.sv =====
// shared types and constants for the chip-8 instruction execute block
package c8x_pkg;

  // default return stack depth
  localparam int C8X_STACK_DEPTH = 16;

  // field widths
  localparam int INSN_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 12;
  localparam int REG_NUM = 16;
  localparam int REG_AW  = 4;

  // program counter after reset
  localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;

  // flag register index
  localparam logic [REG_AW-1:0] FLAG_REG = 4'hF;

  // whole-word system opcodes
  localparam logic [INSN_W-1:0] INSN_CLS = 16'h00E0;
  localparam logic [INSN_W-1:0] INSN_RET = 16'h00EE;

  // top nibble of the opcode
  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_KEY     = 4'hE,
    OP_MISC    = 4'hF
  } opclass_t;

  // low nibble of the 8xyn group
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // register file write
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } reg_wr_t;

endpackage

// ===== rtl/c8x_cmd_if.sv =====
// request channel: instruction word and random byte
interface c8x_cmd_if;
  import c8x_pkg::*;

  logic              valid;
  logic              ready;
  logic [INSN_W-1:0] instruction;
  logic [BYTE_W-1:0] random_byte;

  modport source (output valid, output instruction, output random_byte, input ready);
  modport sink   (input valid, input instruction, input random_byte, output ready);
endinterface

// ===== rtl/c8x_rsp_if.sv =====
// result channel: next pc, index, clear flag and status
interface c8x_rsp_if;
  import c8x_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_pc;
  logic [ADDR_W-1:0] index_value;
  logic              display_clear;
  logic              status;

  modport source (output valid, output next_pc, output index_value,
                  output display_clear, output status, input ready);
  modport sink   (input valid, input next_pc, input index_value,
                  input display_clear, input status, output ready);
endinterface

// ===== rtl/c8x_ram.sv =====
// generic single-write, single-read ram with registered read data
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/chip8_instruction_execute.sv =====
// chip-8 execute: regfile, stack and pc update, one instruction per cycle unless stalled
//
// Takes one CHIP-8 opcode per request and returns next pc, index register, clear-screen
// flag and an unimplemented-opcode status. Sustained rate is one instruction per cycle
// while results are taken; a request passes the execute stage, then the output register.
// V0-VE and the return stack live in synchronous rams read at the request edge; VF, pc,
// index and stack pointer are flip-flops. A write committed by the instruction ahead is
// forwarded into the next one, so back-to-back dependent instructions need no stall. The
// result sits in an output register, so one more request is taken while a result waits.
module chip8_instruction_execute #(
  parameter int STACK_DEPTH = c8x_pkg::C8X_STACK_DEPTH
) (
  input logic        clk,
  input logic        rst,
  c8x_cmd_if.sink    cmd,
  c8x_rsp_if.source  rsp
);
  import c8x_pkg::*;

  localparam int              SPW     = $clog2(STACK_DEPTH);
  localparam logic [SPW-1:0]  SP_LAST = SPW'(STACK_DEPTH - 1);

  // pipeline control
  logic s1_valid;
  logic out_valid;
  logic s1_adv;
  logic acc;

  // execute stage payload
  logic [INSN_W-1:0] s1_insn;
  logic [BYTE_W-1:0] s1_rnd;
  logic [SPW-1:0]    s1_stk_addr;

  // architectural state in flops
  logic [ADDR_W-1:0]  pc;
  logic [ADDR_W-1:0]  idx;
  logic [BYTE_W-1:0]  vf;
  logic [SPW-1:0]     sp;
  logic [REG_NUM-1:0] rf_init;

  // forwarding from the instruction ahead
  reg_wr_t            fwd;
  logic               stk_fwd_hit;
  logic [ADDR_W-1:0]  stk_fwd_data;

  // ram read data
  logic [BYTE_W-1:0] rf_a_q;
  logic [BYTE_W-1:0] rf_b_q;
  logic [ADDR_W-1:0] stk_q;

  // output register
  logic [ADDR_W-1:0] out_pc;
  logic [ADDR_W-1:0] out_idx;
  logic              out_clr;
  logic              out_bad;

  // request side decode
  opclass_t          in_op;
  logic [REG_AW-1:0] in_x;
  logic [REG_AW-1:0] in_b_addr;
  logic              in_call;
  logic              in_ret;
  logic [SPW-1:0]    sp_inc;
  logic [SPW-1:0]    sp_dec;
  logic [SPW-1:0]    sp_next;

  // execute stage decode
  opclass_t          op;
  logic [REG_AW-1:0] x;
  logic [REG_AW-1:0] b_addr;
  logic [3:0]        n;
  logic [BYTE_W-1:0] kk;
  logic [ADDR_W-1:0] nnn;
  logic              s1_call;
  logic [BYTE_W-1:0] vx;
  logic [BYTE_W-1:0] vb;
  logic [ADDR_W-1:0] ret_pc;
  logic [ADDR_W-1:0] pc_adv;

  // execute results
  logic [ADDR_W-1:0] pc_new;
  logic [ADDR_W-1:0] idx_new;
  logic              clr;
  logic              bad;
  logic              skip;
  logic              vx_we;
  logic [BYTE_W-1:0] vx_val;
  logic              flag_we;
  logic              flag_val;
  logic [BYTE_W:0]   sum9;
  reg_wr_t           rf_wr;
  logic              vf_we;
  logic [BYTE_W-1:0] vf_val;

  // handshake
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !s1_valid || s1_adv;
  assign acc       = cmd.valid && cmd.ready;

  // request decode and stack pointer update
  always_comb begin
    in_op     = opclass_t'(cmd.instruction[15:12]);
    in_x      = cmd.instruction[11:8];
    in_b_addr = (in_op == OP_JP_V0) ? '0 : cmd.instruction[7:4];
    in_call   = (in_op == OP_CALL);
    in_ret    = (cmd.instruction == INSN_RET);
    sp_inc    = (sp == SP_LAST) ? '0 : sp + 1'b1;
    sp_dec    = (sp == '0) ? SP_LAST : sp - 1'b1;
    if (in_call) begin
      sp_next = sp_inc;
    end else if (in_ret) begin
      sp_next = sp_dec;
    end else begin
      sp_next = sp;
    end
  end

  // register file, port a reads vx
  c8x_ram #(.WIDTH(BYTE_W), .DEPTH(REG_NUM)) u_rf_a (
    .clk   (clk),
    .we    (rf_wr.en),
    .waddr (rf_wr.addr),
    .wdata (rf_wr.data),
    .re    (acc),
    .raddr (in_x),
    .rdata (rf_a_q)
  );

  // register file copy, port b reads vy or v0
  c8x_ram #(.WIDTH(BYTE_W), .DEPTH(REG_NUM)) u_rf_b (
    .clk   (clk),
    .we    (rf_wr.en),
    .waddr (rf_wr.addr),
    .wdata (rf_wr.data),
    .re    (acc),
    .raddr (in_b_addr),
    .rdata (rf_b_q)
  );

  // return stack
  c8x_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (s1_adv && s1_call),
    .waddr (s1_stk_addr),
    .wdata (pc_adv),
    .re    (acc),
    .raddr (sp_dec),
    .rdata (stk_q)
  );

  // execute stage operand fetch
  always_comb begin
    op      = opclass_t'(s1_insn[15:12]);
    x       = s1_insn[11:8];
    b_addr  = (op == OP_JP_V0) ? '0 : s1_insn[7:4];
    n       = s1_insn[3:0];
    kk      = s1_insn[7:0];
    nnn     = s1_insn[11:0];
    s1_call = (op == OP_CALL);
    pc_adv  = pc + 12'd2;
    ret_pc  = stk_fwd_hit ? stk_fwd_data : stk_q;

    if (x == FLAG_REG) begin
      vx = vf;
    end else if (fwd.en && fwd.addr == x) begin
      vx = fwd.data;
    end else if (rf_init[x]) begin
      vx = rf_a_q;
    end else begin
      vx = '0;
    end

    if (b_addr == FLAG_REG) begin
      vb = vf;
    end else if (fwd.en && fwd.addr == b_addr) begin
      vb = fwd.data;
    end else if (rf_init[b_addr]) begin
      vb = rf_b_q;
    end else begin
      vb = '0;
    end
  end

  // instruction execute
  always_comb begin
    pc_new   = pc_adv;
    idx_new  = idx;
    clr      = 1'b0;
    bad      = 1'b0;
    skip     = 1'b0;
    vx_we    = 1'b0;
    vx_val   = vx;
    flag_we  = 1'b0;
    flag_val = 1'b0;
    sum9     = {1'b0, vx} + {1'b0, vb};

    case (op)
      OP_SYS: begin
        if (s1_insn == INSN_CLS) begin
          clr = 1'b1;
        end else if (s1_insn == INSN_RET) begin
          pc_new = ret_pc;
        end else begin
          bad = 1'b1;
        end
      end
      OP_JP, OP_CALL: begin
        pc_new = nnn;
      end
      OP_SE_IMM: begin
        skip = (vx == kk);
      end
      OP_SNE_IMM: begin
        skip = (vx != kk);
      end
      OP_SE_REG: begin
        if (n == '0) skip = (vx == vb);
        else bad = 1'b1;
      end
      OP_LD_IMM: begin
        vx_we  = 1'b1;
        vx_val = kk;
      end
      OP_ADD_IMM: begin
        vx_we  = 1'b1;
        vx_val = vx + kk;
      end
      OP_ALU: begin
        vx_we = 1'b1;
        case (n)
          ALU_MOV: vx_val = vb;
          ALU_OR:  vx_val = vx | vb;
          ALU_AND: vx_val = vx & vb;
          ALU_XOR: vx_val = vx ^ vb;
          ALU_ADD: begin
            vx_val   = sum9[BYTE_W-1:0];
            flag_we  = 1'b1;
            flag_val = sum9[BYTE_W];
          end
          ALU_SUB: begin
            vx_val   = vx - vb;
            flag_we  = 1'b1;
            flag_val = (vx >= vb);
          end
          ALU_SHR: begin
            vx_val   = {1'b0, vx[BYTE_W-1:1]};
            flag_we  = 1'b1;
            flag_val = vx[0];
          end
          ALU_SUBN: begin
            vx_val   = vb - vx;
            flag_we  = 1'b1;
            flag_val = (vb >= vx);
          end
          ALU_SHL: begin
            vx_val   = {vx[BYTE_W-2:0], 1'b0};
            flag_we  = 1'b1;
            flag_val = vx[BYTE_W-1];
          end
          default: begin
            vx_we = 1'b0;
            bad   = 1'b1;
          end
        endcase
      end
      OP_SNE_REG: begin
        if (n == '0) skip = (vx != vb);
        else bad = 1'b1;
      end
      OP_LD_I: begin
        idx_new = nnn;
      end
      OP_JP_V0: begin
        pc_new = nnn + ADDR_W'(vb);
      end
      OP_RND: begin
        vx_we  = 1'b1;
        vx_val = s1_rnd & kk;
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (skip) begin
      pc_new = pc_adv + 12'd2;
    end

    // vx to ram unless it is vf; the flag is written last and wins
    rf_wr.en   = s1_adv && vx_we && (x != FLAG_REG);
    rf_wr.addr = x;
    rf_wr.data = vx_val;
    vf_we      = s1_adv && (flag_we || (vx_we && x == FLAG_REG));
    vf_val     = flag_we ? BYTE_W'(flag_val) : vx_val;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      sp          <= '0;
      pc          <= PC_RESET;
      idx         <= '0;
      vf          <= '0;
      rf_init     <= '0;
      fwd.en      <= 1'b0;
      stk_fwd_hit <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (acc) begin
        sp          <= sp_next;
        fwd         <= rf_wr;
        stk_fwd_hit <= s1_adv && s1_call && (s1_stk_addr == sp_dec);
      end
      if (s1_adv) begin
        pc  <= pc_new;
        idx <= idx_new;
      end
      if (vf_we) begin
        vf <= vf_val;
      end
      if (rf_wr.en) begin
        rf_init[x] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_insn      <= cmd.instruction;
      s1_rnd       <= cmd.random_byte;
      s1_stk_addr  <= in_call ? sp : sp_dec;
      stk_fwd_data <= pc_adv;
    end
    if (s1_adv) begin
      out_pc  <= pc_new;
      out_idx <= idx_new;
      out_clr <= clr;
      out_bad <= bad;
    end
  end

  // result channel
  assign rsp.valid         = out_valid;
  assign rsp.next_pc       = out_pc;
  assign rsp.index_value   = out_idx;
  assign rsp.display_clear = out_clr;
  assign rsp.status        = out_bad;

endmodule

// ===== rtl/c8x_checker.sv =====
// port-level checks for the chip-8 instruction execute block, bound to the top level
module c8x_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [11:0] rsp_next_pc,
  input logic [11:0] rsp_index_value,
  input logic        rsp_display_clear,
  input logic        rsp_status
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // a new result follows a request through the execute stage and the output register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("result without a request two cycles before");

  // requests are only held off while a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !cmd_ready |-> rsp_valid)
    else $error("request stalled with no pending result");

  // clear screen is an implemented opcode
  a_clear_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_display_clear |-> !rsp_status)
    else $error("clear screen reported as unimplemented");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(rsp_valid && !rsp_ready) |->
      rsp_valid && $stable(rsp_next_pc) && $stable(rsp_index_value)
      && $stable(rsp_display_clear) && $stable(rsp_status))
    else $error("stalled result changed");

endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_next_pc       (rsp.next_pc),
  .rsp_index_value   (rsp.index_value),
  .rsp_display_clear (rsp.display_clear),
  .rsp_status        (rsp.status)
);

// ===== test/c8x_exec_checker.sv =====
// result checker for the chip-8 instruction execute block: tracks cpu state and compares results
`timescale 1ns / 1ps

module c8x_exec_checker (
  input  logic clk,
  input  logic rst,
  c8x_cmd_if   cmd,
  c8x_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   checked
);
  import c8x_pkg::*;

  localparam int DEPTH = C8X_STACK_DEPTH;
  localparam int SHOW_MAX = 10;

  // one result as the block should report it
  typedef struct packed {
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] idx;
    logic              cls;
    logic              unimpl;
  } outcome_t;

  outcome_t          want_q[$];

  // shadow cpu state
  logic [BYTE_W-1:0] v_reg [REG_NUM];
  logic [ADDR_W-1:0] stk [DEPTH];
  logic [ADDR_W-1:0] idx_reg;
  logic [ADDR_W-1:0] pc_reg;
  int                sp;

  // run one instruction on the shadow state and build its outcome
  task execute(input logic [INSN_W-1:0] w, input logic [BYTE_W-1:0] rnd, output outcome_t o);
    logic [3:0]        x, y, n;
    logic [BYTE_W-1:0] kk, vx, vy, res;
    logic [ADDR_W-1:0] nnn, npc;
    logic [BYTE_W:0]   wide;
    logic              flag, sets_flag, skip, cls, unimpl;
    begin
      x = w[11:8];
      y = w[7:4];
      n = w[3:0];
      kk = w[7:0];
      nnn = w[11:0];
      vx = v_reg[x];
      vy = v_reg[y];
      npc = pc_reg + 12'd2;
      cls = 1'b0;
      unimpl = 1'b0;
      skip = 1'b0;
      case (opclass_t'(w[15:12]))
        OP_SYS: begin
          if (w == INSN_CLS) begin
            cls = 1'b1;
          end else if (w == INSN_RET) begin
            sp = (sp + DEPTH - 1) % DEPTH;
            npc = stk[sp];
          end else begin
            unimpl = 1'b1;
          end
        end
        OP_JP: npc = nnn;
        OP_CALL: begin
          stk[sp] = npc;
          sp = (sp + 1) % DEPTH;
          npc = nnn;
        end
        OP_SE_IMM:  skip = (vx == kk);
        OP_SNE_IMM: skip = (vx != kk);
        OP_SE_REG: begin
          if (n == 4'h0) skip = (vx == vy);
          else unimpl = 1'b1;
        end
        OP_LD_IMM:  v_reg[x] = kk;
        OP_ADD_IMM: v_reg[x] = vx + kk;
        OP_ALU: begin
          sets_flag = 1'b1;
          flag = 1'b0;
          res = '0;
          case (n)
            ALU_MOV: begin
              res = vy;
              sets_flag = 1'b0;
            end
            ALU_OR: begin
              res = vx | vy;
              sets_flag = 1'b0;
            end
            ALU_AND: begin
              res = vx & vy;
              sets_flag = 1'b0;
            end
            ALU_XOR: begin
              res = vx ^ vy;
              sets_flag = 1'b0;
            end
            ALU_ADD: begin
              wide = {1'b0, vx} + {1'b0, vy};
              res = wide[BYTE_W-1:0];
              flag = wide[BYTE_W];
            end
            ALU_SUB: begin
              res = vx - vy;
              flag = (vx >= vy);
            end
            ALU_SHR: begin
              res = vx >> 1;
              flag = vx[0];
            end
            ALU_SUBN: begin
              res = vy - vx;
              flag = (vy >= vx);
            end
            ALU_SHL: begin
              res = vx << 1;
              flag = vx[7];
            end
            default: begin
              unimpl = 1'b1;
              sets_flag = 1'b0;
            end
          endcase
          // result first, flag last so vf as target ends up holding the flag
          if (!unimpl) v_reg[x] = res;
          if (sets_flag) v_reg[FLAG_REG] = {7'd0, flag};
        end
        OP_SNE_REG: begin
          if (n == 4'h0) skip = (vx != vy);
          else unimpl = 1'b1;
        end
        OP_LD_I:  idx_reg = nnn;
        OP_JP_V0: npc = nnn + {4'h0, v_reg[0]};
        OP_RND:   v_reg[x] = rnd & kk;
        default:  unimpl = 1'b1;
      endcase
      if (skip) npc = npc + 12'd2;
      pc_reg = npc;
      o = '{pc: npc, idx: idx_reg, cls: cls, unimpl: unimpl};
    end
  endtask

  // watch both channels: compare results first, then predict new requests
  always @(posedge clk) begin
    outcome_t want, got;
    if (rst) begin
      for (int i = 0; i < REG_NUM; i++) v_reg[i] = '0;
      for (int i = 0; i < DEPTH; i++) stk[i] = '0;
      idx_reg = '0;
      pc_reg = PC_RESET;
      sp = 0;
      want_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{pc: rsp.next_pc, idx: rsp.index_value, cls: rsp.display_clear,
                unimpl: rsp.status};
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display({"checker: result with nothing outstanding: ",
                      "pc=%03h idx=%03h cls=%0b st=%0b"},
                     got.pc, got.idx, got.cls, got.unimpl);
        end else begin
          want = want_q.pop_front();
          checked++;
          if (got.pc !== want.pc || got.idx !== want.idx || got.cls !== want.cls ||
              got.unimpl !== want.unimpl) begin
            errors++;
            if (errors <= SHOW_MAX)
              $display({"checker: result %0d: want pc=%03h idx=%03h cls=%0b st=%0b, ",
                        "got pc=%03h idx=%03h cls=%0b st=%0b"},
                       checked, want.pc, want.idx, want.cls, want.unimpl,
                       got.pc, got.idx, got.cls, got.unimpl);
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        execute(cmd.instruction, cmd.random_byte, want);
        want_q.push_back(want);
      end
    end
    pending = want_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the chip-8 instruction execute block: clock, reset, request stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
  import c8x_pkg::*;

  localparam int DEPTH = C8X_STACK_DEPTH;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_AT = 520;
  localparam int HOLD_LEN = 64;
  localparam int TAIL_CYCLES = 10;
  localparam int PHASE_ITEMS = 215;
  localparam int FREE_ITEMS = 180;
  localparam int BURST_DEPTH = DEPTH + 2;
  // an 8xyn code with no operation behind it
  localparam logic [3:0] ALU_NONE = 4'h8;

  logic clk;
  logic rst;

  c8x_cmd_if cmd ();
  c8x_rsp_if rsp ();

  int n_err, n_pend, n_done;
  int n_issued;
  int quiet;
  int snd_idle, rcv_idle;
  bit hold_done;

  // call depth as the issued sequence leaves it, and which slots hold a return address
  int             ret_sp;
  bit [DEPTH-1:0] stk_live;

  chip8_instruction_execute dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  c8x_exec_checker chk (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rsp     (rsp),
    .errors  (n_err),
    .pending (n_pend),
    .checked (n_done)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // opcode builders
  function automatic logic [INSN_W-1:0] enc_xyn(opclass_t c, logic [3:0] x, logic [3:0] y,
                                                logic [3:0] n);
    return {c, x, y, n};
  endfunction

  function automatic logic [INSN_W-1:0] enc_xkk(opclass_t c, logic [3:0] x,
                                                logic [BYTE_W-1:0] kk);
    return {c, x, kk};
  endfunction

  function automatic logic [INSN_W-1:0] enc_nnn(opclass_t c, logic [ADDR_W-1:0] nnn);
    return {c, nnn};
  endfunction

  // byte biased toward edge values so skips and carries hit often
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7F;
      3: return 8'h80;
      4: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed instructions with random fields, a little raw noise
  function automatic logic [INSN_W-1:0] random_insn();
    int                pick;
    logic [3:0]        x, y, n;
    logic [BYTE_W-1:0] kk;
    logic [ADDR_W-1:0] nnn;
    pick = $urandom_range(99);
    x = 4'($urandom_range(15));
    y = 4'($urandom_range(15));
    n = 4'($urandom_range(15));
    kk = pick_byte();
    nnn = 12'($urandom);
    if (pick < 5) return 16'($urandom);
    if (pick < 12) return enc_nnn(OP_CALL, nnn);
    if (pick < 19) return INSN_RET;
    if (pick < 21) return INSN_CLS;
    if (pick < 25) return enc_nnn(OP_SYS, nnn);
    if (pick < 30) return enc_nnn(OP_JP, nnn);
    if (pick < 38) return enc_xkk(pick[0] ? OP_SE_IMM : OP_SNE_IMM, x, kk);
    if (pick < 44) begin
      if ($urandom_range(3) != 0) n = 4'h0;
      return enc_xyn(pick[0] ? OP_SE_REG : OP_SNE_REG, x, y, n);
    end
    if (pick < 55) return enc_xkk(OP_LD_IMM, x, kk);
    if (pick < 62) return enc_xkk(OP_ADD_IMM, x, kk);
    if (pick < 80) begin
      case ($urandom_range(11))
        0: n = ALU_MOV;
        1: n = ALU_OR;
        2: n = ALU_AND;
        3: n = ALU_XOR;
        4: n = ALU_ADD;
        5: n = ALU_SUB;
        6: n = ALU_SHR;
        7: n = ALU_SUBN;
        8: n = ALU_SHL;
        default: ;
      endcase
      return enc_xyn(OP_ALU, x, y, n);
    end
    if (pick < 85) return enc_nnn(OP_LD_I, nnn);
    if (pick < 89) return enc_nnn(OP_JP_V0, nnn);
    if (pick < 95) return enc_xkk(OP_RND, x, kk);
    case ($urandom_range(2))
      0: return enc_nnn(OP_DRW, nnn);
      1: return enc_nnn(OP_KEY, nnn);
      default: return enc_nnn(OP_MISC, nnn);
    endcase
  endfunction

  // offer one request; a return to a never-filled slot becomes a call instead
  task issue(input logic [INSN_W-1:0] w, input logic [BYTE_W-1:0] r);
    int below;
    begin
      below = (ret_sp + DEPTH - 1) % DEPTH;
      if (w == INSN_RET && !stk_live[below]) w = enc_nnn(OP_CALL, 12'($urandom));
      if (w == INSN_RET) begin
        ret_sp = below;
      end else if (w[15:12] == OP_CALL) begin
        stk_live[ret_sp] = 1'b1;
        ret_sp = (ret_sp + 1) % DEPTH;
      end
      while ($urandom_range(99) < snd_idle) begin
        cmd.valid = 1'b0;
        cmd.instruction = 16'($urandom);
        cmd.random_byte = 8'($urandom);
        @(negedge clk);
      end
      cmd.valid = 1'b1;
      cmd.instruction = w;
      cmd.random_byte = r;
      @(posedge clk);
      while (!cmd.ready) @(posedge clk);
      n_issued++;
      @(negedge clk);
    end
  endtask

  task random_run(input int count);
    repeat (count) issue(random_insn(), 8'($urandom));
  endtask

  // stop offering until every outstanding result is back
  task wait_drain();
    cmd.valid = 1'b0;
    do @(negedge clk); while (n_pend != 0);
  endtask

  // result side: random backpressure, plus one long hold-off while requests keep coming
  initial begin
    rsp.ready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    forever begin
      if (!hold_done && n_done >= HOLD_AT) begin
        hold_done = 1'b1;
        rsp.ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        rsp.ready = ($urandom_range(99) >= rcv_idle);
        @(negedge clk);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // request stimulus
  initial begin
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.instruction = '0;
    cmd.random_byte = '0;
    snd_idle = 36;
    rcv_idle = 50;
    n_issued = 0;
    ret_sp = 0;
    stk_live = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, every 8xyn operation, flag target, skips, stack, wraps
    issue(INSN_CLS, 8'($urandom));
    issue(enc_xkk(OP_LD_IMM, 4'h0, 8'h00), 8'($urandom));
    issue(enc_xkk(OP_LD_IMM, 4'h1, 8'hFF), 8'($urandom));
    issue(enc_xkk(OP_ADD_IMM, 4'h1, 8'h01), 8'($urandom));
    issue(enc_xkk(OP_LD_IMM, 4'h2, 8'h80), 8'($urandom));
    issue(enc_xkk(OP_LD_IMM, 4'h3, 8'h7F), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h4, 4'h2, ALU_MOV), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h4, 4'h3, ALU_OR), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h4, 4'h2, ALU_AND), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h4, 4'h3, ALU_XOR), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h2, 4'h2, ALU_ADD), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h2, 4'h3, ALU_SUB), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h3, 4'h3, ALU_SHR), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h4, 4'h1, ALU_SUBN), 8'($urandom));
    issue(enc_xyn(OP_ALU, FLAG_REG, 4'h4, ALU_SHL), 8'($urandom));
    issue(enc_xyn(OP_ALU, 4'h1, 4'h2, ALU_NONE), 8'($urandom));
    issue(enc_xkk(OP_SE_IMM, 4'h0, 8'h00), 8'($urandom));
    issue(enc_xyn(OP_SE_REG, 4'h0, 4'h1, 4'h0), 8'($urandom));
    issue(enc_xyn(OP_SNE_REG, 4'h2, 4'h3, 4'h1), 8'($urandom));
    issue(enc_nnn(OP_LD_I, 12'hFFF), 8'($urandom));
    issue(enc_nnn(OP_CALL, 12'hABC), 8'($urandom));
    issue(INSN_RET, 8'($urandom));
    issue(enc_nnn(OP_JP, 12'hFFE), 8'($urandom));
    issue(enc_xkk(OP_LD_IMM, 4'h0, 8'hFF), 8'($urandom));
    issue(enc_nnn(OP_JP_V0, 12'hFFF), 8'($urandom));
    issue(enc_xkk(OP_RND, 4'h5, 8'hFF), 8'hA5);
    issue(enc_nnn(OP_SYS, 12'h123), 8'($urandom));

    // receiver idles more than the sender
    random_run(PHASE_ITEMS);
    wait_drain();

    // sender idles more than the receiver
    snd_idle = 50;
    rcv_idle = 36;
    random_run(PHASE_ITEMS);
    wait_drain();

    // full rate: nest calls past the stack depth, unwind, then random traffic
    snd_idle = 0;
    rcv_idle = 0;
    repeat (BURST_DEPTH) issue(enc_nnn(OP_CALL, 12'($urandom)), 8'($urandom));
    repeat (BURST_DEPTH) issue(INSN_RET, 8'($urandom));
    random_run(FREE_ITEMS);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("tb_top: %0d instructions sent through directed, backpressured and full-rate phases",
             n_issued);
    $display("tb_top: %0d results compared, %0d mismatches", n_done, n_err);
    if (n_err == 0 && n_pend == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
